@@ src/adhip_pkg.sv @@
// ----------------------------------------------------------------------------
// adhip_pkg
// Shared types and constants for the decimal/hex argument parser.
// ----------------------------------------------------------------------------
package adhip_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int CHAR_W         = 8;
   localparam int DIGIT_W        = 4;
   localparam int RSP_VALUE_W    = 31;
   localparam int RSP_FIELDS_W   = RSP_VALUE_W + 2;
   localparam int RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W      = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;

   localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 4'd9;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_ZERO   = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      hex;
      logic      failed;
   } ctl_type;

   typedef struct packed {
      logic emit;
      logic accepted;
      logic was_hex;
   } res_type;

   localparam ctl_type CTL_RESET = '{phase: PH_START, hex: 1'b0, failed: 1'b0};

endpackage

@@ src/adhip_step.sv @@
// ----------------------------------------------------------------------------
// adhip_step
// Per-character update: prefix phase, digit decode, accumulate and overflow.
// ----------------------------------------------------------------------------
module adhip_step import adhip_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic [CHAR_W-1:0]      char_code,
   input  ctl_type                ctl,
   input  logic [VALUE_BITS-2:0]  sum,
   output ctl_type                ctl_next,
   output logic [VALUE_BITS-2:0]  sum_next,
   output res_type                res,
   output logic [RSP_VALUE_W-1:0] value
);

   localparam int SUM_W = VALUE_BITS - 1;
   localparam int ACC_W = SUM_W + 4;

   logic                         is_nul;
   logic                         is_dec;
   logic                         is_hex_letter;
   logic                         is_digit;
   logic [DIGIT_W-1:0]           digit;
   logic [ACC_W-1:0]             sum_wide;
   logic [ACC_W-1:0]             acc;
   logic                         overflow;
   logic                         take;
   logic [SUM_W+RSP_VALUE_W-1:0] sum_ext;

   assign is_nul = (char_code == CHAR_NUL);
   assign is_dec = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign is_hex_letter = ctl.hex &&
      (((char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F)) ||
       ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F)));
   assign is_digit = is_dec || is_hex_letter;
   assign digit = is_dec ? char_code[DIGIT_W-1:0]
                         : char_code[DIGIT_W-1:0] + LETTER_OFFSET;

   assign sum_wide = {4'b0, sum};
   assign acc = (ctl.hex ? (sum_wide << 4) : ((sum_wide << 3) + (sum_wide << 1)))
                + {{(ACC_W-DIGIT_W){1'b0}}, digit};
   assign overflow = |acc[ACC_W-1:SUM_W];

   assign sum_ext = {{RSP_VALUE_W{1'b0}}, sum};

   // next state
   always_comb begin
      ctl_next = ctl;
      sum_next = sum;
      take     = 1'b0;
      if (is_nul) begin
         ctl_next = CTL_RESET;
         sum_next = '0;
      end else begin
         unique case (ctl.phase)
            PH_START: begin
               if (char_code == CHAR_ZERO) begin
                  ctl_next.phase = PH_ZERO;
               end else if (char_code == CHAR_LOWER_X || char_code == CHAR_UPPER_X) begin
                  ctl_next.hex   = 1'b1;
                  ctl_next.phase = PH_DIGITS;
               end else begin
                  ctl_next.phase = PH_DIGITS;
                  take           = 1'b1;
               end
            end
            PH_ZERO: begin
               if (char_code == CHAR_LOWER_X) begin
                  ctl_next.hex = 1'b1;
               end else begin
                  ctl_next.failed = 1'b1;
               end
               ctl_next.phase = PH_DIGITS;
            end
            default: begin
               take = 1'b1;
            end
         endcase
         if (take && !ctl.failed) begin
            if (!is_digit || overflow) begin
               ctl_next.failed = 1'b1;
            end else begin
               sum_next = acc[SUM_W-1:0];
            end
         end
      end
   end

   // result
   always_comb begin
      res.emit     = is_nul;
      res.accepted = !ctl.failed;
      res.was_hex  = ctl.hex;
      value        = ctl.failed ? '0 : sum_ext[RSP_VALUE_W-1:0];
   end

endmodule

@@ src/adhip_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// adhip_rsp_reg
// Result register: holds one response until the downstream side takes it.
// ----------------------------------------------------------------------------
module adhip_rsp_reg import adhip_pkg::*; #(
   parameter int DATA_W = RSP_DATA_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [DATA_W-1:0] load_data,
   output logic              free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata
);

   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] data_ff;

   assign free       = !valid_ff || rsp_tready;
   assign valid_in   = load || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

@@ src/ascii_dec_hex_integer_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ascii_dec_hex_integer_parser_unit
// Parses a NUL-terminated decimal or hex argument string into an integer.
// ----------------------------------------------------------------------------
// Send one character per request; a NUL request ends the argument and
// produces one response with the value, an accepted flag and a hex flag.
// Decimal is the default; a leading x, X or 0x selects hex. A leading 0 not
// followed by lowercase x or the end, a non-digit, or a sum above the largest
// positive VALUE_BITS signed value rejects the argument (value reads 0).
// Each character is held in the input register and makes one pass through
// the multiply-by-10/16 and overflow logic, so a request is taken every cycle
// while the response register can move; only a NUL waits on a full response.
module ascii_dec_hex_integer_parser_unit import adhip_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_W-1:0]     req_tdata,   // [7:0] char_code
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [30:0] value, [31] accepted, [32] was_hex
);

   localparam int SUM_W = VALUE_BITS - 1;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [CHAR_W-1:0]      in_char_ff;
   ctl_type                ctl_ff;
   ctl_type                ctl_in;
   logic [SUM_W-1:0]       sum_ff;
   logic [SUM_W-1:0]       sum_in;
   res_type                res;
   logic [RSP_VALUE_W-1:0] value;
   logic                   out_free;
   logic                   advance;
   logic                   req_fire;

   adhip_step #(.VALUE_BITS(VALUE_BITS)) u_step (
      .char_code (in_char_ff),
      .ctl       (ctl_ff),
      .sum       (sum_ff),
      .ctl_next  (ctl_in),
      .sum_next  (sum_in),
      .res       (res),
      .value     (value)
   );

   assign advance     = in_valid_ff && (!res.emit || out_free);
   assign req_tready  = !in_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         ctl_ff      <= CTL_RESET;
         sum_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            ctl_ff <= ctl_in;
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata;
      end
   end

   adhip_rsp_reg #(.DATA_W(RSP_DATA_W)) u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && res.emit),
      .load_data  ({{RSP_PAD_W{1'b0}}, res.was_hex, res.accepted, value}),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
